@@ hw/rtl/sha1_hash_engine_macros.svh @@
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define SHA1_ASSERT_INV(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge forces the consequent at the next edge.
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int unsigned CmdFifoDepth = 2;
  localparam int unsigned ChainWords   = 5;
  localparam int unsigned BlockWords   = 16;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // Classified word: payload already masked and padded where needed.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } cmd_t;

  localparam logic [31:0] InitVector [ChainWords] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [31:0] PadWord = 32'h8000_0000;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A82_7999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9_EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if ((rnd >= 7'd40) && (rnd < 7'd60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

@@ hw/rtl/sha1_front.sv @@
`timescale 1ns / 1ps

module sha1_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  sha1_pkg::in_t  in_data_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output sha1_pkg::cmd_t cmd_o
);
  import sha1_pkg::*;

  logic        valid_q;
  cmd_t        cmd_q;
  cmd_t        cmd_d;
  logic        take;
  logic [2:0]  nb;

  assign full        = valid_q & ~cmd_ready_i;
  assign take        = push & ~full;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Clamp the byte count, drop invalid lanes and place the pad byte.
  always_comb begin
    if (!in_data_i.last) begin
      nb = 3'd4;
    end else if (in_data_i.valid_bytes > 3'd4) begin
      nb = 3'd4;
    end else begin
      nb = in_data_i.valid_bytes;
    end
    cmd_d.nbytes = nb;
    cmd_d.last   = in_data_i.last;
    case (nb)
      3'd0:    cmd_d.word = PadWord;
      3'd1:    cmd_d.word = {in_data_i.data_word[31:24], 24'h80_0000};
      3'd2:    cmd_d.word = {in_data_i.data_word[31:16], 16'h8000};
      3'd3:    cmd_d.word = {in_data_i.data_word[31:8], 8'h80};
      default: cmd_d.word = in_data_i.data_word;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

@@ hw/rtl/sha1_fifo.sv @@
`timescale 1ns / 1ps
`include "sha1_hash_engine_macros.svh"

module sha1_fifo #(
  parameter int unsigned Depth = sha1_pkg::CmdFifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sha1_pkg::cmd_t push_data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output sha1_pkg::cmd_t pop_data_o
);
  import sha1_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign ready_o    = (cnt_q != CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i & ready_o;
  assign do_pop     = pop_i & valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `SHA1_ASSERT_INV(a_cnt_le_depth, clk_i, rst_ni, cnt_q <= CntW'(Depth), "fifo overfilled")
  `SHA1_ASSERT_NEXT(a_drain_empty, clk_i, rst_ni, (cnt_q == CntW'(1)) && do_pop && !do_push, !valid_o, "fifo not empty after last pop")

endmodule

@@ hw/rtl/sha1_back.sv @@
`timescale 1ns / 1ps
`include "sha1_hash_engine_macros.svh"

module sha1_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  sha1_pkg::cmd_t cmd_i,
  output logic           empty,
  input  logic           pop,
  output sha1_pkg::out_t out_data_o
);
  import sha1_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_RND   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] R_LOAD  = 2'd0;
  localparam logic [1:0] R_PAD80 = 2'd1;
  localparam logic [1:0] R_ZERO  = 2'd2;
  localparam logic [1:0] R_OUT   = 2'd3;

  localparam logic [3:0] LenWord  = 4'd14;
  localparam logic [3:0] LastWord = 4'd15;
  localparam logic [6:0] LastRnd  = 7'd79;

  logic [2:0]  state_q, state_d;
  logic [1:0]  ret_q, ret_d;
  logic [3:0]  w_q, w_d;
  logic        extra_q, extra_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  k_q, k_d;
  logic [63:0] len_q, len_d;
  logic [31:0] chain_q [ChainWords];
  logic [31:0] chain_d [ChainWords];
  logic [31:0] work_q [ChainWords];
  logic [31:0] work_d [ChainWords];
  logic [31:0] buf_q [BlockWords];
  logic [31:0] buf_d [BlockWords];
  logic        ovalid_q, ovalid_d;
  out_t        out_q, out_d;
  logic        out_pop;
  logic        tail_en;
  logic [31:0] sched_new;
  logic [31:0] a_new;

  assign empty      = ~ovalid_q;
  assign out_data_o = out_q;
  assign out_pop    = pop & ovalid_q;

  assign sched_new = buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0];
  assign a_new = {work_q[0][26:0], work_q[0][31:27]}
               + round_f(rnd_q, work_q[1], work_q[2], work_q[3])
               + work_q[4] + buf_q[0] + round_k(rnd_q);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    w_d       = w_q;
    extra_d   = extra_q;
    rnd_d     = rnd_q;
    k_d       = k_q;
    len_d     = len_q;
    chain_d   = chain_q;
    work_d    = work_q;
    buf_d     = buf_q;
    ovalid_d  = ovalid_q & ~out_pop;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    tail_en   = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          buf_d[w_q] = cmd_i.word;
          if (!cmd_i.last) begin
            len_d = len_q + 64'd32;
            if (w_q == LastWord) begin
              w_d     = '0;
              ret_d   = R_LOAD;
              state_d = S_RND;
            end else begin
              w_d = w_q + 4'd1;
            end
          end else begin
            len_d = len_q + {58'd0, cmd_i.nbytes, 3'd0};
            if (cmd_i.nbytes == 3'd4) begin
              if (w_q == LastWord) begin
                w_d     = '0;
                ret_d   = R_PAD80;
                state_d = S_RND;
              end else begin
                w_d     = w_q + 4'd1;
                state_d = S_PAD80;
              end
            end else begin
              tail_en = 1'b1;
            end
          end
        end
      end
      S_PAD80: begin
        buf_d[w_q] = PadWord;
        tail_en    = 1'b1;
      end
      S_ZERO: begin
        if (extra_q) begin
          buf_d[w_q] = '0;
          if (w_q == LastWord) begin
            w_d     = '0;
            extra_d = 1'b0;
            ret_d   = R_ZERO;
            state_d = S_RND;
          end else begin
            w_d = w_q + 4'd1;
          end
        end else if (w_q == LenWord) begin
          state_d = S_LEN;
        end else begin
          buf_d[w_q] = '0;
          w_d        = w_q + 4'd1;
        end
      end
      S_LEN: begin
        buf_d[LenWord]  = len_q[63:32];
        buf_d[LastWord] = len_q[31:0];
        w_d             = '0;
        ret_d           = R_OUT;
        state_d         = S_RND;
      end
      S_RND: begin
        work_d[0] = a_new;
        work_d[1] = work_q[0];
        work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
        work_d[3] = work_q[2];
        work_d[4] = work_q[3];
        for (int i = 0; i < BlockWords - 1; i++) begin
          buf_d[i] = buf_q[i+1];
        end
        buf_d[BlockWords-1] = {sched_new[30:0], sched_new[31]};
        if (rnd_q == LastRnd) begin
          rnd_d   = '0;
          state_d = S_FIN;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      S_FIN: begin
        for (int i = 0; i < ChainWords; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        unique case (ret_q)
          R_LOAD:  state_d = S_LOAD;
          R_PAD80: state_d = S_PAD80;
          R_ZERO:  state_d = S_ZERO;
          R_OUT: begin
            k_d     = '0;
            state_d = S_OUT;
          end
          default: state_d = S_LOAD;
        endcase
      end
      S_OUT: begin
        if (!ovalid_q || out_pop) begin
          ovalid_d          = 1'b1;
          out_d.digest_word = chain_q[k_q];
          out_d.word_index  = k_q;
          out_d.last_word   = (k_q == 3'(ChainWords - 1));
          if (k_q == 3'(ChainWords - 1)) begin
            chain_d = InitVector;
            len_d   = '0;
            w_d     = '0;
            k_d     = '0;
            state_d = S_LOAD;
          end else begin
            k_d = k_q + 3'd1;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase

    // After the word that holds the pad byte: fill with zeros, spill to a
    // second block when the length words no longer fit.
    if (tail_en) begin
      if (w_q == LastWord) begin
        w_d     = '0;
        extra_d = 1'b0;
        ret_d   = R_ZERO;
        state_d = S_RND;
      end else if (w_q == LenWord) begin
        w_d     = LastWord;
        extra_d = 1'b1;
        state_d = S_ZERO;
      end else begin
        w_d     = w_q + 4'd1;
        extra_d = 1'b0;
        state_d = S_ZERO;
      end
    end

    // Seed the working variables on entry to a compression.
    if ((state_d == S_RND) && (state_q != S_RND)) begin
      work_d = chain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      ret_q    <= R_LOAD;
      w_q      <= '0;
      extra_q  <= 1'b0;
      rnd_q    <= '0;
      k_q      <= '0;
      len_q    <= '0;
      chain_q  <= InitVector;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      w_q      <= w_d;
      extra_q  <= extra_d;
      rnd_q    <= rnd_d;
      k_q      <= k_d;
      len_q    <= len_d;
      chain_q  <= chain_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    buf_q  <= buf_d;
    out_q  <= out_d;
  end

  `SHA1_ASSERT_INV(a_rnd_range, clk_i, rst_ni, rnd_q <= LastRnd, "round counter out of range")
  `SHA1_ASSERT_INV(a_last_flag, clk_i, rst_ni, !ovalid_q || (out_q.last_word == (out_q.word_index == 3'(ChainWords - 1))), "last_word mismatch")
  `SHA1_ASSERT_NEXT(a_rnd_to_fin, clk_i, rst_ni, (state_q == S_RND) && (rnd_q == LastRnd), state_q == S_FIN, "compression did not finish")

endmodule

@@ hw/rtl/sha1_hash_engine.sv @@
`timescale 1ns / 1ps
// A last word passes the front register and command queue to the core, which pads the block;
// each compression runs 80 rounds plus the chaining add, twice if padding spills.
// Throughput: one word per cycle into the core while it loads a block; it takes no words
// while its single round unit compresses. Digest beats leave one per cycle when popped.
// Reset: async, active low; queues empty, chain at the initial vector, length zero.
module sha1_hash_engine #(
  parameter int unsigned CmdFifoDepth = sha1_pkg::CmdFifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  sha1_pkg::in_t  in_data_i,
  output logic           empty,
  input  logic           pop,
  output sha1_pkg::out_t out_data_o
);
  import sha1_pkg::*;

  // Front register -> command queue -> compression core.
  logic front_valid;
  logic fifo_ready;
  cmd_t front_cmd;
  logic core_valid;
  logic core_pop;
  cmd_t core_cmd;

  // Classify each input beat: clamp byte count, mask lanes, place the pad byte.
  sha1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (fifo_ready),
    .cmd_o       (front_cmd)
  );

  // Decouple the front from the core so each side can stall on its own.
  sha1_fifo #(
    .Depth (CmdFifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_cmd),
    .ready_o     (fifo_ready),
    .valid_o     (core_valid),
    .pop_i       (core_pop),
    .pop_data_o  (core_cmd)
  );

  // Fill the block, pad, run rounds, and hold digest beats in the output register.
  sha1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (core_valid),
    .cmd_pop_o   (core_pop),
    .cmd_i       (core_cmd),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  import sha1_pkg::in_t;
  import sha1_pkg::out_t;

  // One row of stimulus. Rows whose digest is a well-known test vector carry it
  // typed in; every other row is checked against the predictor alone.
  typedef struct {
    in_t          beat;
    bit           known;
    logic [159:0] known_digest;
  } stim_row_t;

  localparam int unsigned DrainCycles = 400;     // two compressions plus padding, with slack
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 4000;    // long receiver hold-off
  localparam int unsigned RandWords   = 105;

  localparam logic [31:0] Iv0 = 32'h6745_2301;
  localparam logic [31:0] Iv1 = 32'hEFCD_AB89;
  localparam logic [31:0] Iv2 = 32'h98BA_DCFE;
  localparam logic [31:0] Iv3 = 32'h1032_5476;
  localparam logic [31:0] Iv4 = 32'hC3D2_E1F0;

  localparam logic [31:0] KRound0 = 32'h5A82_7999;
  localparam logic [31:0] KRound1 = 32'h6ED9_EBA1;
  localparam logic [31:0] KRound2 = 32'h8F1B_BCDC;
  localparam logic [31:0] KRound3 = 32'hCA62_C1D6;

  localparam logic [31:0] PadMarker = 32'h8000_0000;

  localparam logic [159:0] DigestEmpty = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] DigestAbc   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  in_t  in_data_i = '0;
  logic full;
  logic empty;
  out_t out_data_o;

  always #2 clk_i = ~clk_i;

  sha1_hash_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  stim_row_t stim_rows[$];
  int unsigned directed_rows;

  // Counters in this group, some read by other processes, move by nonblocking assignment only.
  int unsigned send_ptr = 0;   // next row the sender offers
  int unsigned n_in     = 0;   // input beats accepted so far
  int unsigned phase    = 0;   // idling phase, follows input progress
  int unsigned cycles   = 0;

  out_t        pending_digest[$];
  int unsigned err_cnt = 0;

  // Predictor state: block words, chaining value, byte fill and bit length.
  logic [31:0] blk[16];
  logic [31:0] chain[5];
  int unsigned blk_bytes;
  logic [63:0] msg_bits;

  task automatic add_row(input logic [31:0] data, input logic [2:0] nbytes, input logic lst,
                         input bit known = 1'b0, input logic [159:0] digest = '0);
    stim_row_t r;
    r.beat.data_word   = data;
    r.beat.valid_bytes = nbytes;
    r.beat.last        = lst;
    r.known            = known;
    r.known_digest     = digest;
    stim_rows.push_back(r);
  endtask

  function automatic void restart_chain();
    chain[0]  = Iv0;
    chain[1]  = Iv1;
    chain[2]  = Iv2;
    chain[3]  = Iv3;
    chain[4]  = Iv4;
    blk_bytes = 0;
    msg_bits  = '0;
  endfunction

  // Run the 80 rounds over blk and fold the result into the chaining value.
  function automatic void mix_block();
    logic [31:0] sched[80];
    logic [31:0] a, b, c, d, e, f, k, x, t;
    for (int i = 0; i < 16; i++) begin
      sched[i] = blk[i];
    end
    for (int i = 16; i < 80; i++) begin
      x        = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
      sched[i] = {x[30:0], x[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      case (r / 20)
        0: begin
          f = (b & c) | (~b & d);
          k = KRound0;
        end
        1: begin
          f = b ^ c ^ d;
          k = KRound1;
        end
        2: begin
          f = (b & c) | (b & d) | (c & d);
          k = KRound2;
        end
        default: begin
          f = b ^ c ^ d;
          k = KRound3;
        end
      endcase
      t = {a[26:0], a[31:27]} + f + e + sched[r] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
    blk_bytes = 0;
  endfunction

  // Absorb one accepted word; on a last word pad, finish, and queue the five digest beats.
  function automatic void sha_absorb(input in_t beat);
    int unsigned wi;
    int unsigned nb;
    logic [31:0] mask;
    out_t        dw;
    wi = (blk_bytes >> 2) & 15;
    if (!beat.last) begin
      // valid_bytes means nothing before the last word
      blk[wi]   = beat.data_word;
      msg_bits += 64'd32;
      blk_bytes = (wi + 1) * 4;
      if (blk_bytes >= 64) begin
        mix_block();
      end
      return;
    end
    nb = (beat.valid_bytes > 3'd4) ? 4 : beat.valid_bytes;
    msg_bits += 64'(nb * 8);
    if (nb < 4) begin
      // drop the lanes past the valid bytes and place the marker right after them
      mask    = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
      blk[wi] = (beat.data_word & mask) | (32'h80 << (24 - 8 * nb));
      wi++;
    end else begin
      blk[wi] = beat.data_word;
      wi++;
      if (wi >= 16) begin
        mix_block();
        wi = 0;
      end
      blk[wi] = PadMarker;
      wi++;
    end
    if (wi > 14) begin
      // no room for the length: spill into an extra block
      while (wi < 16) begin
        blk[wi] = '0;
        wi++;
      end
      mix_block();
      wi = 0;
    end
    while (wi < 14) begin
      blk[wi] = '0;
      wi++;
    end
    blk[14] = msg_bits[63:32];
    blk[15] = msg_bits[31:0];
    mix_block();
    for (int i = 0; i < 5; i++) begin
      dw.digest_word = chain[i];
      dw.word_index  = 3'(i);
      dw.last_word   = (i == 4);
      pending_digest.push_back(dw);
    end
    restart_chain();
  endfunction

  task automatic flag_error(input string what, input out_t want, input out_t got);
    if (err_cnt < 10) begin
      $display("[%0t] %s: expected word %08h idx %0d last %0b, got word %08h idx %0d last %0b",
               $realtime, what, want.digest_word, want.word_index, want.last_word,
               got.digest_word, got.word_index, got.last_word);
    end
    err_cnt++;
  endtask

  // Sender: hold the beat while full blocks it, otherwise advance or go idle.
  always @(posedge clk_i) begin : sender
    int unsigned nxt;
    int unsigned idle_pct;
    if (rst_ni && !(push && full)) begin
      nxt = send_ptr + (push ? 1 : 0);
      case (phase)
        1:       idle_pct = 84;
        3:       idle_pct = 23;
        default: idle_pct = 0;
      endcase
      send_ptr <= nxt;
      if (nxt < stim_rows.size() && $urandom_range(99) >= idle_pct) begin
        push      <= 1'b1;
        in_data_i <= stim_rows[nxt].beat;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per phase, plus one long hold-off early in the random part
  // while the sender keeps offering, so the engine backs up and raises full.
  always @(posedge clk_i) begin : receiver
    int unsigned stall_pct;
    int unsigned hold_left;
    bit          held;
    if (!rst_ni) begin
      pop       <= 1'b0;
      hold_left = 0;
      held      = 1'b0;
    end else if (!held && n_in >= directed_rows) begin
      held      = 1'b1;
      hold_left = HoldCycles;
      pop       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (phase)
        2:       stall_pct = 84;
        3:       stall_pct = 23;
        default: stall_pct = 0;
      endcase
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: feed accepted input beats to the predictor, check every digest beat.
  always @(posedge clk_i) begin : monitor
    out_t want;
    int unsigned base;
    if (rst_ni) begin
      if (push && !full) begin
        sha_absorb(in_data_i);
        if (in_data_i.last && stim_rows[n_in].known) begin
          // take the published vector instead of the predictor's digest
          base = pending_digest.size() - 5;
          for (int i = 0; i < 5; i++) begin
            pending_digest[base + i].digest_word = stim_rows[n_in].known_digest[159 - 32 * i -: 32];
          end
        end
        n_in  <= n_in + 1;
        phase <= ((n_in + 1) * 4) / stim_rows.size();
      end
      if (pop && !empty) begin
        if (pending_digest.size() == 0) begin
          flag_error("unexpected digest beat", '0, out_data_o);
        end else begin
          want = pending_digest.pop_front();
          if (out_data_o.digest_word !== want.digest_word ||
              out_data_o.word_index  !== want.word_index  ||
              out_data_o.last_word   !== want.last_word) begin
            flag_error("digest mismatch", want, out_data_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n_rand;
    int unsigned len;
    int unsigned sel;
    restart_chain();
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
    end

    // Directed part: known vectors first, so they see a fresh chaining value.
    add_row(32'h0000_0000, 3'd0, 1'b1, 1'b1, DigestEmpty);   // empty message
    add_row(32'h6162_63FF, 3'd3, 1'b1, 1'b1, DigestAbc);     // "abc", junk in the dead lane
    add_row(32'hFFFF_FFFF, 3'd7, 1'b1);                      // byte count above four
    add_row(32'h0000_0000, 3'd1, 1'b0);                      // short count ignored mid-message
    add_row(32'hFFFF_FFFF, 3'd6, 1'b0);
    add_row(32'hA5A5_A5A5, 3'd2, 1'b1);
    add_row(32'hFFFF_FFFF, 3'd4, 1'b1);                      // one full word
    for (int i = 0; i < 13; i++) begin                       // marker lands at byte 56
      add_row(32'h0101_0101 * (i + 1), 3'd4, 1'b0);
    end
    add_row(32'hDEAD_BEEF, 3'd4, 1'b1);
    directed_rows = stim_rows.size();

    // Random part: whole messages, mostly short, many around the block boundary.
    n_rand = 0;
    while (n_rand < RandWords) begin
      sel = $urandom_range(9);
      if (sel < 5) begin
        len = $urandom_range(6);
      end else if (sel < 8) begin
        len = $urandom_range(17, 13);
      end else begin
        len = $urandom_range(34, 28);
      end
      for (int i = 0; i < len; i++) begin
        add_row($urandom, 3'($urandom_range(7)), 1'b0);
      end
      add_row($urandom, 3'($urandom_range(7)), 1'b1);
      n_rand += len + 1;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_in < stim_rows.size()) @(posedge clk_i);
    while (pending_digest.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && pending_digest.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sha1_hash_engine.f @@
+incdir+hw/rtl
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_front.sv
hw/rtl/sha1_fifo.sv
hw/rtl/sha1_back.sv
hw/rtl/sha1_hash_engine.sv
tb/tb_top.sv
